### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion violated");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

### hw/rtl/bef_pkg.sv
// ----------------------------------------------------------------------------
// bef_pkg: shared types and constants of the eased fade generator
// Transaction payload types and the fixed constants of the fade arithmetic.
// ----------------------------------------------------------------------------
package bef_pkg;

  localparam int LEVEL_W = 8;
  localparam int WAIT_W  = 18;

  localparam int MIN_STEPS       = 6;
  localparam int MIN_DUR_MS      = 500;
  localparam int MAX_DUR_MS      = 1000;
  localparam int MS_PER_LEVEL    = 20;
  localparam int US_PER_MS       = 1000;
  localparam int LAST_LEVEL_INIT = 255;

  typedef struct packed {
    logic [LEVEL_W-1:0] start_level;
    logic [LEVEL_W-1:0] target_level;
  } bef_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               write_level;
    logic [WAIT_W-1:0]  wait_us;
    logic               last_step;
  } bef_res_t;

endpackage

### hw/rtl/bef_if.sv
// ----------------------------------------------------------------------------
// bef_if: valid/ready channels of the eased fade generator
// One interface for fade requests and one for step results.
// ----------------------------------------------------------------------------
interface bef_req_if import bef_pkg::*; ();
  logic     valid;
  logic     ready;
  bef_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bef_res_if import bef_pkg::*; ();
  logic     valid;
  logic     ready;
  bef_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/backlight_eased_fade_generator_core.sv
// ----------------------------------------------------------------------------
// backlight_eased_fade_generator_core: cubic ease-in-out backlight fade
// Turns each fade request into a sequence of eased level steps with hold times.
// ----------------------------------------------------------------------------
//
//  Channel | Modport   | Payload                                   | Per transaction
//  --------+-----------+-------------------------------------------+-----------------
//  req     | sink      | start_level, target_level                 | one fade request
//  res     | source    | level, write_level, wait_us, last_step    | one fade step
//
// Flow: a request whose levels are within one of each other goes straight to the
// emit state for its single result. Any other request first runs a setup
// (four multiplies and the wait division) and then emits steps + 1 steps, each
// with its own level division. The divider is DIVD_W bits wide (27 bits at
// the default MAX_STEPS of 32) and bit-serial: one quotient bit per cycle.
// Reset is synchronous and active high; it returns the sequencer to idle and
// drops the result valid. A stalled result holds its register, and the
// sequencer waits in its emit state until the result register is free.
//
module backlight_eased_fade_generator_core
  import bef_pkg::*;
#(
  parameter int MAX_STEPS = 32
) (
  input  logic          clk,
  input  logic          rst,
  bef_req_if.sink       req,
  bef_res_if.source     res
);

  // Widths that follow from the largest step count.
  localparam int SW      = $clog2(MAX_STEPS + 1);
  localparam int CUBE_W  = $clog2(MAX_STEPS * MAX_STEPS * MAX_STEPS + 1);
  localparam int DUR_W   = 10;
  localparam int DUS_W   = 20;
  localparam int MA_W    = (CUBE_W > DUR_W) ? CUBE_W : DUR_W;
  localparam int MB_W    = 11;
  localparam int PROD_W  = MA_W + MB_W + 1;
  localparam int NUM_W   = CUBE_W + 11;
  localparam int DIVD_W  = (NUM_W > DUS_W) ? NUM_W : DUS_W;
  localparam int DVS_W   = CUBE_W + 1;
  localparam int CNT_W   = $clog2(DIVD_W + 1);

  // Sequencer state codes.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;  // steps * steps
  localparam logic [3:0] ST_CUBE = 4'd2;  // square * steps
  localparam logic [3:0] ST_FS   = 4'd3;  // start level * cube
  localparam logic [3:0] ST_DUR  = 4'd4;  // duration * 1000
  localparam logic [3:0] ST_DIV  = 4'd5;  // shared bit-serial divider
  localparam logic [3:0] ST_ER1  = 4'd6;  // r * r
  localparam logic [3:0] ST_ER2  = 4'd7;  // r^2 * r
  localparam logic [3:0] ST_ER3  = 4'd8;  // delta * eased numerator
  localparam logic [3:0] ST_EMIT = 4'd9;

  logic [3:0]          state;

  // Request context.
  logic [SW-1:0]       steps_r;
  logic [DUR_W-1:0]    dur_r;
  logic [LEVEL_W-1:0]  from_r;
  logic signed [LEVEL_W:0] delta_r;
  logic [SW-1:0]       idx;
  logic                small_r;
  logic [LEVEL_W-1:0]  last_wr;

  // Arithmetic registers.
  logic [CUBE_W-1:0]   cube_r;
  logic [CUBE_W-1:0]   m_r;
  logic [NUM_W-1:0]    base_r;
  logic [WAIT_W-1:0]   wait_r;
  logic [LEVEL_W-1:0]  lvl_r;

  // Divider registers.
  logic [DIVD_W-1:0]   dvd;
  logic [DVS_W-1:0]    dvs;
  logic [DVS_W-1:0]    rem;
  logic [CNT_W-1:0]    div_cnt;
  logic                div_wait;

  // Result register.
  logic                out_valid;
  bef_res_t            out_data;

  // --------------------------------------------------------------------------
  // Request decode, evaluated on the incoming payload at acceptance.
  // --------------------------------------------------------------------------
  logic signed [LEVEL_W:0] in_delta;
  logic [LEVEL_W-1:0]      in_d;
  logic [LEVEL_W:0]        in_2d;
  logic [SW-1:0]           in_steps;
  logic [12:0]             in_dur_raw;
  logic [DUR_W-1:0]        in_dur;

  always_comb begin
    in_delta   = $signed({1'b0, req.data.target_level}) -
                 $signed({1'b0, req.data.start_level});
    in_d       = in_delta[LEVEL_W] ? LEVEL_W'(-in_delta) : in_delta[LEVEL_W-1:0];
    in_2d      = {in_d, 1'b0};
    if (in_2d < (LEVEL_W+1)'(MIN_STEPS)) begin
      in_steps = SW'(MIN_STEPS);
    end else if ({1'b0, in_2d} > 10'(MAX_STEPS)) begin
      in_steps = SW'(MAX_STEPS);
    end else begin
      in_steps = SW'(in_2d);
    end
    // 20 * d as a shift-add.
    in_dur_raw = {1'b0, in_d, 4'b0000} + {3'b000, in_d, 2'b00};
    if (in_dur_raw < 13'(MIN_DUR_MS)) begin
      in_dur = DUR_W'(MIN_DUR_MS);
    end else if (in_dur_raw > 13'(MAX_DUR_MS)) begin
      in_dur = DUR_W'(MAX_DUR_MS);
    end else begin
      in_dur = DUR_W'(in_dur_raw);
    end
  end

  // --------------------------------------------------------------------------
  // Step geometry: the curve is mirrored around the midpoint, so r is the
  // distance from the nearer end of the fade.
  // --------------------------------------------------------------------------
  logic              lower_half;
  logic [SW-1:0]     r_val;
  logic [CUBE_W+1:0] four_m;
  logic [CUBE_W-1:0] e_val;

  always_comb begin
    lower_half = {idx, 1'b0} < {1'b0, steps_r};
    r_val      = lower_half ? idx : (steps_r - idx);
    four_m     = {m_r, 2'b00};
    e_val      = lower_half ? CUBE_W'(four_m) : (cube_r - CUBE_W'(four_m));
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: unsigned A by signed B, operands picked by the state.
  // --------------------------------------------------------------------------
  logic [MA_W-1:0]          mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    case (state)
      ST_SQ: begin
        mul_a = MA_W'(steps_r);
        mul_b = $signed(MB_W'(steps_r));
      end
      ST_CUBE: begin
        mul_a = MA_W'(cube_r);
        mul_b = $signed(MB_W'(steps_r));
      end
      ST_FS: begin
        mul_a = MA_W'(cube_r);
        mul_b = $signed(MB_W'(from_r));
      end
      ST_DUR: begin
        mul_a = MA_W'(dur_r);
        mul_b = MB_W'(US_PER_MS);
      end
      ST_ER1: begin
        mul_a = MA_W'(r_val);
        mul_b = $signed(MB_W'(r_val));
      end
      ST_ER2: begin
        mul_a = MA_W'(m_r);
        mul_b = $signed(MB_W'(r_val));
      end
      ST_ER3: begin
        mul_a = MA_W'(e_val);
        mul_b = MB_W'(delta_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = $signed({1'b0, mul_a}) * mul_b;
  end

  // Level numerator 2*from*S + 2*delta*E + S, always non-negative.
  logic [NUM_W-1:0] num_val;
  assign num_val = base_r + {prod[NUM_W-2:0], 1'b0};

  // --------------------------------------------------------------------------
  // Restoring divider step: one quotient bit per cycle.
  // --------------------------------------------------------------------------
  logic [DVS_W:0]    trial;
  logic              qbit;
  logic [DVS_W-1:0]  rem_next;
  logic [DIVD_W-1:0] quot;

  always_comb begin
    trial    = {rem, dvd[DIVD_W-1]};
    qbit     = trial >= {1'b0, dvs};
    rem_next = qbit ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
    quot     = {dvd[DIVD_W-2:0], qbit};
  end

  logic [LEVEL_W-1:0] emit_level;
  logic               emit_last;
  assign emit_level = small_r ? from_r : lvl_r;
  assign emit_last  = small_r || (idx == steps_r);

  // A step is loaded into the result register when the register is free or
  // is being emptied in the same cycle.
  logic               emit_fire;
  assign emit_fire = (state == ST_EMIT) && (!out_valid || res.ready);

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            delta_r <= in_delta;
            steps_r <= in_steps;
            dur_r   <= in_dur;
            idx     <= '0;
            last_wr <= LEVEL_W'(LAST_LEVEL_INIT);
            if (in_d <= LEVEL_W'(1)) begin
              // Near-equal levels: drive the target directly.
              small_r <= 1'b1;
              from_r  <= req.data.target_level;
              state   <= ST_EMIT;
            end else begin
              small_r <= 1'b0;
              from_r  <= req.data.start_level;
              state   <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          cube_r <= CUBE_W'(prod);
          state  <= ST_CUBE;
        end
        ST_CUBE: begin
          cube_r <= CUBE_W'(prod);
          state  <= ST_FS;
        end
        ST_FS: begin
          base_r <= NUM_W'({prod[CUBE_W+7:0], 1'b0}) + NUM_W'(cube_r);
          state  <= ST_DUR;
        end
        ST_DUR: begin
          dvd      <= DIVD_W'(prod[DUS_W-1:0]);
          dvs      <= DVS_W'(steps_r);
          rem      <= '0;
          div_cnt  <= CNT_W'(DIVD_W);
          div_wait <= 1'b1;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          dvd     <= quot;
          rem     <= rem_next;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == CNT_W'(1)) begin
            if (div_wait) begin
              wait_r <= quot[WAIT_W-1:0];
              state  <= ST_ER1;
            end else begin
              lvl_r <= quot[LEVEL_W-1:0];
              state <= ST_EMIT;
            end
          end
        end
        ST_ER1: begin
          m_r   <= CUBE_W'(prod);
          state <= ST_ER2;
        end
        ST_ER2: begin
          m_r   <= CUBE_W'(prod);
          state <= ST_ER3;
        end
        ST_ER3: begin
          dvd      <= DIVD_W'(num_val);
          dvs      <= {cube_r, 1'b0};
          rem      <= '0;
          div_cnt  <= CNT_W'(DIVD_W);
          div_wait <= 1'b0;
          state    <= ST_DIV;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            out_valid            <= 1'b1;
            out_data.level       <= emit_level;
            out_data.write_level <= small_r || (emit_level != last_wr);
            out_data.wait_us     <= small_r ? '0 : wait_r;
            out_data.last_step   <= emit_last;
            last_wr              <= emit_level;
            if (emit_last) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_ER1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign res.valid = out_valid;
  assign res.data  = out_data;

endmodule

### hw/rtl/bef_checker.sv
// ----------------------------------------------------------------------------
// bef_checker: port-level checks of the eased fade generator
// Watches the request and result channels and flags protocol or sequencing slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bef_checker
  import bef_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [WAIT_W-1:0]  res_wait_us,
  input logic               res_write_level,
  input logic               res_last_step
);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)

  // A request occupies the block, so no request is taken in the next cycle.
  `ASSERT_NEXT(a_req_busy, clk, rst, req_valid && req_ready, !req_ready)

  // Only the single-result case has a zero hold time, and it always drives.
  `ASSERT_IMPL(a_zero_wait, clk, rst, res_valid && (res_wait_us == '0),
               res_last_step && res_write_level)

  // Intermediate steps of a fade always carry a hold time.
  `ASSERT_IMPL(a_step_wait, clk, rst, res_valid && !res_last_step, res_wait_us != '0)

endmodule

bind backlight_eased_fade_generator_core bef_checker u_bef_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_wait_us     (res.data.wait_us),
  .res_write_level (res.data.write_level),
  .res_last_step   (res.data.last_step)
);

### dv/backlight_eased_fade_generator_core_test.sv
// ----------------------------------------------------------------------------
// backlight_eased_fade_generator_core_test: self-checking bench for the fade core
// Sends fade requests over the request channel and checks every eased step
// against a cycle-free predictor. It covers the near-equal levels, the range
// extremes, the step and duration clamps, write suppression, random traffic
// under several idle mixes, and a long result back-pressure stretch.
// ----------------------------------------------------------------------------
module backlight_eased_fade_generator_core_test;
  import bef_pkg::*;

  localparam int FADE_MAX_STEPS = 32;
  // Drain margin after the last owed step, ample for the core to go quiet.
  localparam int DRAIN_CYCLES   = 100;
  // Length of the long receiver hold-off in the back-pressure test.
  localparam int HOLD_OFF_CYCLES = 3000;

  logic clk;
  logic rst;

  bef_req_if req_ch ();
  bef_res_if res_ch ();

  backlight_eased_fade_generator_core #(
    .MAX_STEPS(FADE_MAX_STEPS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // Steps that the core still owes, oldest first.
  bef_res_t expected_steps[$];

  int send_idle_pct     = 0;
  int recv_stall_pct    = 0;
  int ready_hold_cycles = 0;
  int requests_sent     = 0;
  int steps_checked     = 0;
  int mismatches        = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit, several times the slowest legal run.
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

  // Works out every step of one fade request and queues it. The eased fraction
  // is kept exact as a ratio over steps cubed, and the level is rounded half up.
  function automatic void predict_fade_steps(input logic [LEVEL_W-1:0] from_lvl,
                                             input logic [LEVEL_W-1:0] to_lvl);
    longint delta;
    longint span;
    longint steps;
    longint dur_ms;
    longint cube;
    longint eased;
    longint rest;
    longint num;
    logic [LEVEL_W-1:0] driven;
    logic [WAIT_W-1:0]  hold_us;
    bef_res_t           step;

    delta = longint'(to_lvl) - longint'(from_lvl);
    span  = (delta < 0) ? -delta : delta;

    // Levels within one of each other are driven directly in a single step.
    if (span <= 1) begin
      step.level       = to_lvl;
      step.write_level = 1'b1;
      step.wait_us     = '0;
      step.last_step   = 1'b1;
      expected_steps.push_back(step);
      return;
    end

    steps = 2 * span;
    if (steps < MIN_STEPS) steps = MIN_STEPS;
    if (steps > FADE_MAX_STEPS) steps = FADE_MAX_STEPS;
    dur_ms = MS_PER_LEVEL * span;
    if (dur_ms < MIN_DUR_MS) dur_ms = MIN_DUR_MS;
    if (dur_ms > MAX_DUR_MS) dur_ms = MAX_DUR_MS;
    hold_us = WAIT_W'((dur_ms * US_PER_MS) / steps);

    cube   = steps * steps * steps;
    driven = LEVEL_W'(LAST_LEVEL_INIT);
    for (longint i = 0; i <= steps; i++) begin
      if (2 * i < steps) begin
        eased = 4 * i * i * i;
      end else begin
        rest  = steps - i;
        eased = cube - 4 * rest * rest * rest;
      end
      num = 2 * longint'(from_lvl) * cube + 2 * delta * eased + cube;
      step.level       = LEVEL_W'(num / (2 * cube));
      step.write_level = (step.level != driven);
      if (step.write_level) driven = step.level;
      step.wait_us     = hold_us;
      step.last_step   = (i == steps);
      expected_steps.push_back(step);
    end
  endfunction

  // Receiver: random stalls, plus a counted hold-off when a test asks for one.
  always @(negedge clk) begin
    if (ready_hold_cycles > 0) begin
      res_ch.ready <= 1'b0;
      ready_hold_cycles = ready_hold_cycles - 1;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic report_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // Every result transaction is matched against the oldest owed step.
  always @(posedge clk) begin
    bef_res_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected step, expected none, got level %0d last %0b",
                 $time, res_ch.data.level, res_ch.data.last_step);
        mismatches++;
      end else begin
        want = expected_steps.pop_front();
        report_field("level", 32'(want.level), 32'(res_ch.data.level));
        report_field("write_level", 32'(want.write_level), 32'(res_ch.data.write_level));
        report_field("wait_us", 32'(want.wait_us), 32'(res_ch.data.wait_us));
        report_field("last_step", 32'(want.last_step), 32'(res_ch.data.last_step));
        steps_checked++;
      end
    end
  end

  // Offers one request from a falling edge and returns at a falling edge. Valid
  // stays high when no idle gap is drawn, so back-to-back requests stay tight.
  task automatic send_fade(input logic [LEVEL_W-1:0] from_lvl,
                           input logic [LEVEL_W-1:0] to_lvl);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.data  <= '{start_level: from_lvl, target_level: to_lvl};
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predict_fade_steps(from_lvl, to_lvl);
    requests_sent++;
    @(negedge clk);
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drops valid and waits for a falling edge, so the next request starts clean.
  task automatic park_request_channel();
    req_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_near_equal_levels();
    send_fade(8'd0, 8'd0);
    send_fade(8'd255, 8'd255);
    send_fade(8'd0, 8'd1);
    send_fade(8'd1, 8'd0);
    send_fade(8'd254, 8'd255);
    send_fade(8'd255, 8'd254);
    send_fade(8'd128, 8'd129);
    park_request_channel();
  endtask

  task automatic test_full_range_fades();
    send_fade(8'd0, 8'd255);
    send_fade(8'd255, 8'd0);
    park_request_channel();
  endtask

  // Distances that sit on either side of the step and duration clamps.
  task automatic test_step_and_duration_clamps();
    send_fade(8'd10, 8'd12);
    send_fade(8'd43, 8'd40);
    send_fade(8'd60, 8'd70);
    send_fade(8'd100, 8'd116);
    send_fade(8'd100, 8'd125);
    send_fade(8'd0, 8'd26);
    send_fade(8'd200, 8'd150);
    send_fade(8'd0, 8'd60);
    park_request_channel();
  endtask

  // Repeated levels and a first step that equals the initial driven level.
  task automatic test_write_suppression();
    send_fade(8'd255, 8'd200);
    send_fade(8'd3, 8'd0);
    send_fade(8'd0, 8'd2);
    send_fade(8'd250, 8'd255);
    park_request_channel();
  endtask

  // Mix of near-equal, short and arbitrary fades under one idle and stall setting.
  task automatic test_random_fades(input int count, input int idle_pct, input int stall_pct);
    int from_lvl;
    int to_lvl;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      from_lvl = $urandom_range(0, 255);
      case ($urandom_range(0, 9))
        0, 1: to_lvl = from_lvl ^ $urandom_range(0, 1);
        2, 3, 4: begin
          to_lvl = from_lvl + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(2, 20);
          if (to_lvl < 0 || to_lvl > 255) to_lvl = 2 * from_lvl - to_lvl;
        end
        default: to_lvl = $urandom_range(0, 255);
      endcase
      send_fade(from_lvl[7:0], to_lvl[7:0]);
    end
    park_request_channel();
  endtask

  // The receiver holds off long enough for the core to fill and refuse input,
  // while full-length fades keep being offered back to back.
  task automatic test_result_backpressure();
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    ready_hold_cycles = HOLD_OFF_CYCLES;
    repeat (4) begin
      send_fade(LEVEL_W'($urandom_range(0, 40)), LEVEL_W'($urandom_range(200, 255)));
    end
    park_request_channel();
  endtask

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    res_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_near_equal_levels();
    test_full_range_fades();
    test_step_and_duration_clamps();
    test_write_suppression();
    test_random_fades(66, 0, 0);
    test_random_fades(66, 45, 0);
    test_random_fades(66, 0, 45);
    test_random_fades(66, 26, 26);
    test_result_backpressure();

    while (expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d fade requests and %0d eased steps, with idle mixes and a long hold-off.",
             requests_sent, steps_checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
